@@ src/video_chip_register_interface_defines.svh @@
// ----------------------------------------------------------------------------
// video_chip_register_interface_defines.svh
// Assertion macros used by the register interface top module.
// ----------------------------------------------------------------------------
`ifndef VIDEO_CHIP_REGISTER_INTERFACE_DEFINES_SVH
`define VIDEO_CHIP_REGISTER_INTERFACE_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define VCRI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define VCRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/vcri_pkg.sv @@
// ----------------------------------------------------------------------------
// vcri_pkg
// Types and constants of the video chip register interface.
// ----------------------------------------------------------------------------
package vcri_pkg;

    localparam int unsigned SPRITE_BYTES = 256;
    localparam int unsigned SPR_AW       = $clog2(SPRITE_BYTES);
    localparam int unsigned LINE_W       = 9;

    localparam logic [LINE_W:0]   LINES_PER_FRAME = 10'd262;
    localparam logic [LINE_W-1:0] VBLANK_LINE     = 9'd240;

    localparam int unsigned CTRL_NMI_BIT    = 7;
    localparam int unsigned CTRL_STEP32_BIT = 2;

    localparam int unsigned ST_VBLANK = 2;
    localparam int unsigned ST_HIT    = 1;
    localparam int unsigned ST_OVF    = 0;

    localparam logic [15:0] STEP_NARROW = 16'd1;
    localparam logic [15:0] STEP_WIDE   = 16'd32;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_DMA   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } t_reg;

    typedef struct packed {
        t_cmd        cmd;
        t_reg        reg_index;
        logic [7:0]  wdata;
        logic [7:0]  vram_rdata;
        logic [7:0]  dma_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        nmi;
        logic        frame_done;
        logic [15:0] vram_addr;
        logic        vram_rd;
        logic        vram_wr;
        logic [7:0]  vram_wdata;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [SPR_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

endpackage

@@ src/vcri_in_if.sv @@
// ----------------------------------------------------------------------------
// vcri_in_if
// Request channel: valid/ready with the request word's fields.
// ----------------------------------------------------------------------------
interface vcri_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] reg_index;
    logic [7:0] wdata;
    logic [7:0] vram_rdata;
    logic [7:0] dma_index;

    modport source (
        output valid, cmd, reg_index, wdata, vram_rdata, dma_index,
        input  ready
    );

    modport sink (
        input  valid, cmd, reg_index, wdata, vram_rdata, dma_index,
        output ready
    );

endinterface

@@ src/vcri_out_if.sv @@
// ----------------------------------------------------------------------------
// vcri_out_if
// Result channel: valid/ready with the result word's fields.
// ----------------------------------------------------------------------------
interface vcri_out_if;

    logic        valid;
    logic        ready;
    logic [7:0]  rdata;
    logic        nmi;
    logic        frame_done;
    logic [15:0] vram_addr;
    logic        vram_rd;
    logic        vram_wr;
    logic [7:0]  vram_wdata;

    modport source (
        output valid, rdata, nmi, frame_done, vram_addr, vram_rd, vram_wr, vram_wdata,
        input  ready
    );

    modport sink (
        input  valid, rdata, nmi, frame_done, vram_addr, vram_rd, vram_wr, vram_wdata,
        output ready
    );

endinterface

@@ src/vcri_oam_ram.sv @@
// ----------------------------------------------------------------------------
// vcri_oam_ram
// 256 x 8 sprite store, registered read, write-to-read bypass, valid bits.
// ----------------------------------------------------------------------------
module vcri_oam_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [vcri_pkg::SPR_AW-1:0]   i_rd_addr,
    input  vcri_pkg::t_ram_wr             i_wr,
    output logic [7:0]                    o_rd_data
);

    logic [7:0]                        r_mem [vcri_pkg::SPRITE_BYTES];
    logic [vcri_pkg::SPRITE_BYTES-1:0] r_valid;
    logic [7:0]                        r_q;
    logic                              r_q_valid;
    logic                              r_byp;
    logic [7:0]                        r_byp_data;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // same-edge write to the read address wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else if (i_rd_en) begin
            r_q_valid <= r_valid[i_rd_addr];
            r_byp     <= i_wr.we && (i_wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_q_valid ? r_q : 8'h00);

endmodule

@@ src/vcri_exec.sv @@
// ----------------------------------------------------------------------------
// vcri_exec
// Register file and per-word update: one request word executed per fire.
// ----------------------------------------------------------------------------
module vcri_exec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  vcri_pkg::t_in_word            i_item,
    input  logic [7:0]                    i_spr_rdata,
    output vcri_pkg::t_out_word           o_res,
    output vcri_pkg::t_ram_wr             o_ram_wr,
    output logic [vcri_pkg::SPR_AW-1:0]   o_next_ptr
);

    logic [7:0]                    r_ctrl,    n_ctrl;
    logic [2:0]                    r_status,  n_status;
    logic [vcri_pkg::SPR_AW-1:0]   r_ptr,     n_ptr;
    logic [15:0]                   r_vaddr,   n_vaddr;
    logic [7:0]                    r_latch,   n_latch;
    logic [7:0]                    r_first,   n_first;
    logic                          r_toggle,  n_toggle;
    logic [vcri_pkg::LINE_W-1:0]   r_line,    n_line;
    logic [7:0]                    r_spr0,    n_spr0;

    logic [15:0]                   step;
    logic [vcri_pkg::LINE_W:0]     line_inc;

    assign step     = r_ctrl[vcri_pkg::CTRL_STEP32_BIT] ? vcri_pkg::STEP_WIDE
                                                        : vcri_pkg::STEP_NARROW;
    assign line_inc = {1'b0, r_line} + {{vcri_pkg::LINE_W{1'b0}}, 1'b1};

    always_comb begin
        n_ctrl   = r_ctrl;
        n_status = r_status;
        n_ptr    = r_ptr;
        n_vaddr  = r_vaddr;
        n_latch  = r_latch;
        n_first  = r_first;
        n_toggle = r_toggle;
        n_line   = r_line;
        o_res    = '0;
        o_ram_wr = '0;

        unique case (i_item.cmd)
            vcri_pkg::CMD_READ: begin
                unique case (i_item.reg_index)
                    vcri_pkg::REG_STATUS: begin
                        n_latch = {r_status, r_latch[4:0]};
                        n_status[vcri_pkg::ST_VBLANK] = 1'b0;
                        n_toggle = 1'b0;
                    end
                    vcri_pkg::REG_OAMDATA: begin
                        n_latch = i_spr_rdata;
                    end
                    vcri_pkg::REG_DATA: begin
                        n_latch         = i_item.vram_rdata;
                        o_res.vram_addr = r_vaddr;
                        o_res.vram_rd   = 1'b1;
                        n_vaddr         = r_vaddr + step;
                    end
                    default: begin
                        // write-only register: latch returned as is
                    end
                endcase
            end
            vcri_pkg::CMD_WRITE: begin
                n_latch = i_item.wdata;
                unique case (i_item.reg_index)
                    vcri_pkg::REG_CTRL: begin
                        o_res.nmi = !r_ctrl[vcri_pkg::CTRL_NMI_BIT]
                                 && i_item.wdata[vcri_pkg::CTRL_NMI_BIT]
                                 && r_status[vcri_pkg::ST_VBLANK];
                        n_ctrl = i_item.wdata;
                    end
                    vcri_pkg::REG_OAMADDR: begin
                        n_ptr = i_item.wdata[vcri_pkg::SPR_AW-1:0];
                    end
                    vcri_pkg::REG_OAMDATA: begin
                        o_ram_wr.we   = 1'b1;
                        o_ram_wr.addr = r_ptr;
                        o_ram_wr.data = i_item.wdata;
                        n_ptr         = r_ptr + {{(vcri_pkg::SPR_AW-1){1'b0}}, 1'b1};
                    end
                    vcri_pkg::REG_SCROLL, vcri_pkg::REG_ADDR: begin
                        if (r_toggle) begin
                            if (i_item.reg_index == vcri_pkg::REG_ADDR) begin
                                n_vaddr = {r_first, i_item.wdata};
                            end
                            n_toggle = 1'b0;
                        end else begin
                            n_first  = i_item.wdata;
                            n_toggle = 1'b1;
                        end
                    end
                    vcri_pkg::REG_DATA: begin
                        o_res.vram_addr  = r_vaddr;
                        o_res.vram_wr    = 1'b1;
                        o_res.vram_wdata = i_item.wdata;
                        n_vaddr          = r_vaddr + step;
                    end
                    default: begin
                        // mask and status: latch only
                    end
                endcase
            end
            vcri_pkg::CMD_TICK: begin
                if (r_line == '0) begin
                    n_status = '0;
                end
                if ((r_line < vcri_pkg::VBLANK_LINE)
                        && ({1'b0, r_spr0} == r_line)) begin
                    n_status[vcri_pkg::ST_HIT] = 1'b1;
                end
                if (r_line == vcri_pkg::VBLANK_LINE) begin
                    n_status[vcri_pkg::ST_VBLANK] = 1'b1;
                    o_res.nmi = r_ctrl[vcri_pkg::CTRL_NMI_BIT];
                end
                if (line_inc >= vcri_pkg::LINES_PER_FRAME) begin
                    n_line           = '0;
                    o_res.frame_done = 1'b1;
                end else begin
                    n_line = line_inc[vcri_pkg::LINE_W-1:0];
                end
            end
            vcri_pkg::CMD_DMA: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = i_item.dma_index;
                o_ram_wr.data = i_item.wdata;
            end
        endcase

        // the store is written only at the edge where the word executes
        o_ram_wr.we = o_ram_wr.we && i_fire;

        o_res.rdata = n_latch;
    end

    // copy of sprite byte 0 for the hit compare on ticks
    always_comb begin
        n_spr0 = r_spr0;
        if (o_ram_wr.we && (o_ram_wr.addr == '0)) begin
            n_spr0 = o_ram_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_status <= '0;
            r_ptr    <= '0;
            r_vaddr  <= '0;
            r_latch  <= '0;
            r_first  <= '0;
            r_toggle <= 1'b0;
            r_line   <= '0;
            r_spr0   <= '0;
        end else if (i_fire) begin
            r_ctrl   <= n_ctrl;
            r_status <= n_status;
            r_ptr    <= n_ptr;
            r_vaddr  <= n_vaddr;
            r_latch  <= n_latch;
            r_first  <= n_first;
            r_toggle <= n_toggle;
            r_line   <= n_line;
            r_spr0   <= n_spr0;
        end
    end

    // pointer the next word sees, for the early sprite read
    assign o_next_ptr = i_fire ? n_ptr : r_ptr;

endmodule

@@ src/video_chip_register_interface.sv @@
// A word waits in stage 1 until the output register is free or draining, then executes.
// Throughput: one word per cycle, every command, no bubbles, while the result side is ready.
// The sprite store read for an OAM data read is issued at accept; the registered
// read of that memory port sets the two-stage depth.
// Reset: synchronous, active low; register file and valid bits clear at once, not held words.
// ----------------------------------------------------------------------------
// video_chip_register_interface
// CPU-side register block of a video chip: control, status, address/scroll
// pairs, sprite store and scanline counter, one result word per request word.
// ----------------------------------------------------------------------------
`include "video_chip_register_interface_defines.svh"

module video_chip_register_interface (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vcri_in_if.sink     i_in,
    vcri_out_if.source  o_out
);

    // Stage 1 holds the accepted word while the sprite store read completes.
    logic                          r_s1_valid;
    vcri_pkg::t_in_word            r_s1_item;

    // Output register: parts the request side from the result side.
    logic                          r_out_valid;
    vcri_pkg::t_out_word           r_out_word;

    logic                          in_acc;
    logic                          exec_fire;
    vcri_pkg::t_out_word           res;
    vcri_pkg::t_ram_wr             ram_wr;
    logic [vcri_pkg::SPR_AW-1:0]   next_ptr;
    logic [7:0]                    spr_rdata;

    // A word executes once the output register is free or being emptied.
    assign exec_fire  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || exec_fire;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (exec_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item.cmd        <= vcri_pkg::t_cmd'(i_in.cmd);
            r_s1_item.reg_index  <= vcri_pkg::t_reg'(i_in.reg_index);
            r_s1_item.wdata      <= i_in.wdata;
            r_s1_item.vram_rdata <= i_in.vram_rdata;
            r_s1_item.dma_index  <= i_in.dma_index;
        end
    end

    // Sprite store: read at the pointer left by the word now executing,
    // written by that word in the same edge (bypassed inside the RAM).
    vcri_oam_ram u_oam_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (next_ptr),
        .i_wr      (ram_wr),
        .o_rd_data (spr_rdata)
    );

    vcri_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (exec_fire),
        .i_item      (r_s1_item),
        .i_spr_rdata (spr_rdata),
        .o_res       (res),
        .o_ram_wr    (ram_wr),
        .o_next_ptr  (next_ptr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_word <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.rdata      = r_out_word.rdata;
    assign o_out.nmi        = r_out_word.nmi;
    assign o_out.frame_done = r_out_word.frame_done;
    assign o_out.vram_addr  = r_out_word.vram_addr;
    assign o_out.vram_rd    = r_out_word.vram_rd;
    assign o_out.vram_wr    = r_out_word.vram_wr;
    assign o_out.vram_wdata = r_out_word.vram_wdata;

    // executed word always lands in the output register
    `VCRI_ASSERT_NEXT(a_exec_lands, exec_fire, r_out_valid, "executed word not presented")
    // a waiting result is never overwritten
    `VCRI_ASSERT_NOW(a_no_overwrite, r_out_valid && !o_out.ready, !exec_fire, "result overwritten")
    // stalled stage 1 keeps its word
    `VCRI_ASSERT_NEXT(a_s1_hold, r_s1_valid && !exec_fire, r_s1_valid && $stable(r_s1_item), "stage 1 word lost")
    // a result never requests both a read and a write of video memory
    `VCRI_ASSERT_NOW(a_rd_wr_excl, r_out_valid, !(r_out_word.vram_rd && r_out_word.vram_wr), "vram read and write together")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: video chip register interface
// Drives register reads and writes, scanline ticks and sprite DMA bytes into
// the block; checks every result word against the hand-written result of a
// typed table row, else an in-bench model of the registers, sprite store and
// line counter. A directed table comes first, then random sequences shaped
// like real CPU traffic, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_TARGET = 1050;  // total words before the stimulus stops
    localparam int HOLD_CYCLES   = 120;   // long result-side hold-off
    localparam int PRINT_CAP     = 40;    // mismatch lines printed before going quiet

    logic i_clk = 1'b0;
    logic i_rst_n;

    vcri_in_if  in_if ();
    vcri_out_if out_if ();

    video_chip_register_interface uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Register model: its own copy of every piece of block state.
    // ------------------------------------------------------------------------
    logic [7:0]  ctrl_m;
    logic [7:0]  mask_m;
    logic [2:0]  flags_m;          // vblank, sprite-zero hit, overflow
    logic [7:0]  sprite_mem [vcri_pkg::SPRITE_BYTES];
    logic [7:0]  sprite_ptr_m;
    logic [15:0] vaddr_m;
    logic [7:0]  latch_m;
    logic [7:0]  held_byte_m;      // first byte of a scroll/address pair
    logic        toggle_m;
    logic [7:0]  scroll_x_m;
    logic [7:0]  scroll_y_m;
    logic [8:0]  line_m;

    task automatic clear_model();
        ctrl_m       = '0;
        mask_m       = '0;
        flags_m      = '0;
        sprite_ptr_m = '0;
        vaddr_m      = '0;
        latch_m      = '0;
        held_byte_m  = '0;
        toggle_m     = 1'b0;
        scroll_x_m   = '0;
        scroll_y_m   = '0;
        line_m       = '0;
        for (int i = 0; i < vcri_pkg::SPRITE_BYTES; i++) sprite_mem[i] = '0;
    endtask

    function automatic logic [15:0] next_vaddr();
        return vaddr_m + (ctrl_m[vcri_pkg::CTRL_STEP32_BIT] ? vcri_pkg::STEP_WIDE
                                                            : vcri_pkg::STEP_NARROW);
    endfunction

    // Works out the result word of one accepted word and moves the model on.
    function automatic vcri_pkg::t_out_word predict_register_access(
            input vcri_pkg::t_in_word w);
        vcri_pkg::t_out_word r;
        logic [9:0]          nxt;
        r = '0;
        case (w.cmd)
            vcri_pkg::CMD_READ: begin
                case (w.reg_index)
                    vcri_pkg::REG_STATUS: begin
                        latch_m                      = {flags_m, latch_m[4:0]};
                        flags_m[vcri_pkg::ST_VBLANK] = 1'b0;
                        toggle_m                     = 1'b0;
                    end
                    vcri_pkg::REG_OAMDATA: latch_m = sprite_mem[sprite_ptr_m];
                    vcri_pkg::REG_DATA: begin
                        latch_m     = w.vram_rdata;
                        r.vram_addr = vaddr_m;
                        r.vram_rd   = 1'b1;
                        vaddr_m     = next_vaddr();
                    end
                    default: ;  // write-only register: bus latch comes back as is
                endcase
            end
            vcri_pkg::CMD_WRITE: begin
                latch_m = w.wdata;
                case (w.reg_index)
                    vcri_pkg::REG_CTRL: begin
                        // enabling NMI during vblank fires one straight away
                        if (!ctrl_m[vcri_pkg::CTRL_NMI_BIT]
                                && w.wdata[vcri_pkg::CTRL_NMI_BIT]
                                && flags_m[vcri_pkg::ST_VBLANK])
                            r.nmi = 1'b1;
                        ctrl_m = w.wdata;
                    end
                    vcri_pkg::REG_MASK:    mask_m = w.wdata;
                    vcri_pkg::REG_OAMADDR: sprite_ptr_m = w.wdata;
                    vcri_pkg::REG_OAMDATA: begin
                        sprite_mem[sprite_ptr_m] = w.wdata;
                        sprite_ptr_m             = sprite_ptr_m + 8'd1;
                    end
                    vcri_pkg::REG_SCROLL: begin
                        if (toggle_m) begin
                            scroll_x_m = held_byte_m;
                            scroll_y_m = w.wdata;
                        end else begin
                            held_byte_m = w.wdata;
                        end
                        toggle_m = !toggle_m;
                    end
                    vcri_pkg::REG_ADDR: begin
                        if (toggle_m) vaddr_m = {held_byte_m, w.wdata};
                        else          held_byte_m = w.wdata;
                        toggle_m = !toggle_m;
                    end
                    vcri_pkg::REG_DATA: begin
                        r.vram_addr  = vaddr_m;
                        r.vram_wr    = 1'b1;
                        r.vram_wdata = w.wdata;
                        vaddr_m      = next_vaddr();
                    end
                    default: ;  // status is read-only
                endcase
            end
            vcri_pkg::CMD_TICK: begin
                if (line_m == '0) flags_m = '0;
                if (line_m < vcri_pkg::VBLANK_LINE && {1'b0, sprite_mem[0]} == line_m)
                    flags_m[vcri_pkg::ST_HIT] = 1'b1;
                if (line_m == vcri_pkg::VBLANK_LINE) begin
                    flags_m[vcri_pkg::ST_VBLANK] = 1'b1;
                    if (ctrl_m[vcri_pkg::CTRL_NMI_BIT]) r.nmi = 1'b1;
                end
                nxt = {1'b0, line_m} + 10'd1;
                if (nxt >= vcri_pkg::LINES_PER_FRAME) nxt = '0;
                line_m       = nxt[8:0];
                r.frame_done = (line_m == '0);
            end
            default: sprite_mem[w.dma_index] = w.wdata;  // DMA: latch and pointer untouched
        endcase
        r.rdata = latch_m;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------
    vcri_pkg::t_out_word responses_due [$];
    int                  mismatches;
    bit                  drive_typed;      // word on the bus carries a hand-written result
    vcri_pkg::t_out_word drive_want;
    int                  words_sent;
    int                  n_ticks, n_frames, n_nmi, n_vram;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch
        vcri_pkg::t_in_word  w;
        vcri_pkg::t_out_word want;
        vcri_pkg::t_out_word got;
        if (i_rst_n) begin
            // accept first, so a result in the same edge would still find its entry
            if (in_if.valid && in_if.ready) begin
                w.cmd        = vcri_pkg::t_cmd'(in_if.cmd);
                w.reg_index  = vcri_pkg::t_reg'(in_if.reg_index);
                w.wdata      = in_if.wdata;
                w.vram_rdata = in_if.vram_rdata;
                w.dma_index  = in_if.dma_index;
                want = predict_register_access(w);
                if (w.cmd == vcri_pkg::CMD_TICK) n_ticks++;
                if (want.frame_done) n_frames++;
                if (want.nmi) n_nmi++;
                if (want.vram_rd || want.vram_wr) n_vram++;
                responses_due.push_back(drive_typed ? drive_want : want);
            end
            if (out_if.valid && out_if.ready) begin
                got.rdata      = out_if.rdata;
                got.nmi        = out_if.nmi;
                got.frame_done = out_if.frame_done;
                got.vram_addr  = out_if.vram_addr;
                got.vram_rd    = out_if.vram_rd;
                got.vram_wr    = out_if.vram_wr;
                got.vram_wdata = out_if.vram_wdata;
                if (responses_due.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want = responses_due.pop_front();
                    check_field("rdata",      16'(got.rdata),      16'(want.rdata));
                    check_field("nmi",        16'(got.nmi),        16'(want.nmi));
                    check_field("frame_done", 16'(got.frame_done), 16'(want.frame_done));
                    check_field("vram_addr",  got.vram_addr,       want.vram_addr);
                    check_field("vram_rd",    16'(got.vram_rd),    16'(want.vram_rd));
                    check_field("vram_wr",    16'(got.vram_wr),    16'(want.vram_wr));
                    check_field("vram_wdata", 16'(got.vram_wdata), 16'(want.vram_wdata));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: randomly redrawn stall patterns; one long hold-off.
    // ------------------------------------------------------------------------
    bit hold_off;

    initial begin
        hold_off = 1'b0;
        wait (words_sent >= 350);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : sink_side
        int         mode;
        int         left;
        logic [7:0] pat;
        out_if.ready = 1'b0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(2, 0);
                pat  = 8'($urandom_range(255, 1));
                left = 48;
            end
            left--;
            pat = {pat[6:0], pat[7]};
            if (hold_off)       out_if.ready <= 1'b0;
            else if (mode == 0) out_if.ready <= 1'b1;             // no stalls
            else if (mode == 1) out_if.ready <= pat[0];           // rotating pattern
            else                out_if.ready <= ($urandom_range(3, 0) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    int burst_left;

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input vcri_pkg::t_in_word w, input bit typed = 1'b0,
                             input vcri_pkg::t_out_word want = '0);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(6, 0);
            burst_left = $urandom_range(24, 1);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        drive_typed = typed;
        drive_want  = want;
        in_if.valid      <= 1'b1;
        in_if.cmd        <= w.cmd;
        in_if.reg_index  <= w.reg_index;
        in_if.wdata      <= w.wdata;
        in_if.vram_rdata <= w.vram_rdata;
        in_if.dma_index  <= w.dma_index;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Sender stands back until every outstanding result has come out.
    task automatic drain_responses();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (responses_due.size() != 0) @(negedge i_clk);
    endtask

    function automatic vcri_pkg::t_in_word noise_word();
        vcri_pkg::t_in_word w;
        w.cmd        = vcri_pkg::t_cmd'($urandom_range(3, 0));
        w.reg_index  = vcri_pkg::t_reg'($urandom_range(7, 0));
        w.wdata      = 8'($urandom_range(255, 0));
        w.vram_rdata = 8'($urandom_range(255, 0));
        w.dma_index  = 8'($urandom_range(255, 0));
        return w;
    endfunction

    function automatic vcri_pkg::t_in_word word_of(input vcri_pkg::t_cmd c,
                                                   input vcri_pkg::t_reg r);
        vcri_pkg::t_in_word w;
        w           = noise_word();
        w.cmd       = c;
        w.reg_index = r;
        return w;
    endfunction

    // One random chunk of bus traffic. Most chunks are the sequences a CPU
    // actually issues; the rest is single words of noise.
    task automatic send_random_sequence();
        vcri_pkg::t_in_word w;
        vcri_pkg::t_cmd     c;
        int                 kind;
        int                 n;
        logic [7:0]         base;
        kind = $urandom_range(99, 0);
        // inside vblank, lean towards NMI enables and status polls
        if (flags_m[vcri_pkg::ST_VBLANK] && kind < 50) kind = 90;
        if (kind < 40) begin
            n = $urandom_range(12, 1);
            repeat (n) send_word(word_of(vcri_pkg::CMD_TICK, vcri_pkg::REG_CTRL));
        end else if (kind < 55) begin
            // address pair, then a run of data accesses
            send_word(word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_ADDR));
            send_word(word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_ADDR));
            n = $urandom_range(6, 1);
            repeat (n) begin
                c = $urandom_range(1, 0) ? vcri_pkg::CMD_WRITE : vcri_pkg::CMD_READ;
                send_word(word_of(c, vcri_pkg::REG_DATA));
            end
        end else if (kind < 65) begin
            w = word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_OAMADDR);
            if ($urandom_range(2, 0) == 0) w.wdata = '0;
            send_word(w);
            n = $urandom_range(5, 1);
            repeat (n) begin
                c = $urandom_range(1, 0) ? vcri_pkg::CMD_WRITE : vcri_pkg::CMD_READ;
                w = word_of(c, vcri_pkg::REG_OAMDATA);
                if (w.cmd == vcri_pkg::CMD_WRITE && sprite_ptr_m == '0
                        && $urandom_range(3, 0) != 0)
                    w.wdata = 8'($urandom_range(239, 0));   // keep sprite 0 on screen
                send_word(w);
            end
        end else if (kind < 72) begin
            base = ($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 0));
            n    = $urandom_range(8, 1);
            for (int k = 0; k < n; k++) begin
                w           = word_of(vcri_pkg::CMD_DMA, vcri_pkg::REG_CTRL);
                w.dma_index = base + 8'(k);
                if (w.dma_index == '0 && $urandom_range(3, 0) != 0)
                    w.wdata = 8'($urandom_range(239, 0));
                send_word(w);
            end
        end else if (kind < 78) begin
            send_word(word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_SCROLL));
            send_word(word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_SCROLL));
        end else if (kind < 86) begin
            send_word(noise_word());
        end else begin
            // NMI enable off, maybe a status poll, then back on
            w = word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_CTRL);
            w.wdata[vcri_pkg::CTRL_NMI_BIT] = 1'b0;
            send_word(w);
            if ($urandom_range(1, 0))
                send_word(word_of(vcri_pkg::CMD_READ, vcri_pkg::REG_STATUS));
            w = word_of(vcri_pkg::CMD_WRITE, vcri_pkg::REG_CTRL);
            w.wdata[vcri_pkg::CTRL_NMI_BIT] = 1'b1;
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef struct {
        vcri_pkg::t_in_word  w;
        bit                  typed;
        vcri_pkg::t_out_word want;
    } t_directed_row;

    t_directed_row directed_rows [$];

    task automatic add_row(input vcri_pkg::t_cmd c, input vcri_pkg::t_reg r,
                           input logic [7:0] wd, input logic [7:0] vrd,
                           input logic [7:0] di,
                           input bit typed = 1'b0, input logic [7:0] rdata = '0,
                           input logic [15:0] addr = '0, input bit rd = 1'b0,
                           input bit wr = 1'b0, input logic [7:0] wbyte = '0);
        t_directed_row row;
        row.w.cmd             = c;
        row.w.reg_index       = r;
        row.w.wdata           = wd;
        row.w.vram_rdata      = vrd;
        row.w.dma_index       = di;
        row.typed             = typed;
        row.want              = '0;
        row.want.rdata        = rdata;
        row.want.vram_addr    = addr;
        row.want.vram_rd      = rd;
        row.want.vram_wr      = wr;
        row.want.vram_wdata   = wbyte;
        directed_rows.push_back(row);
    endtask

    initial begin : time_limit
        #400000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        bit paused;
        int waited;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.cmd        = '0;
        in_if.reg_index  = '0;
        in_if.wdata      = '0;
        in_if.vram_rdata = '0;
        in_if.dma_index  = '0;
        drive_typed      = 1'b0;
        drive_want       = '0;
        mismatches       = 0;
        words_sent       = 0;
        burst_left       = 0;
        paused           = 1'b0;
        clear_model();

        // reset state, write-only reads, latch, address wrap at the top
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_STATUS,  8'h00, 8'hFF, 8'h00, 1'b1, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_CTRL,    8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_CTRL,    8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_CTRL,    8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_MASK,    8'hA5, 8'h00, 8'h00, 1'b1, 8'hA5);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_ADDR,    8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_ADDR,    8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_DATA,    8'h5A, 8'h00, 8'h00, 1'b1, 8'h5A,
                16'hFFFF, 1'b0, 1'b1, 8'h5A);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_DATA,    8'h00, 8'hC3, 8'h00, 1'b1, 8'hC3,
                16'h0000, 1'b1, 1'b0, 8'h00);
        // sprite store: pointer, write-and-step, read-without-step, DMA
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_OAMADDR, 8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_OAMDATA, 8'h03, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_OAMADDR, 8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_OAMDATA, 8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_DMA,   vcri_pkg::REG_CTRL,    8'hFF, 8'h00, 8'hFF);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_OAMADDR, 8'hFF, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_OAMDATA, 8'h00, 8'h00, 8'h00);
        // wide address step
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_CTRL,    8'h04, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_DATA,    8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_DATA,    8'h00, 8'hFF, 8'h00);
        // scroll pair, then a lone first write whose toggle a status read clears
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_SCROLL,  8'h12, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_SCROLL,  8'h34, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_WRITE, vcri_pkg::REG_SCROLL,  8'h55, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_STATUS,  8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_READ,  vcri_pkg::REG_SCROLL,  8'h00, 8'h00, 8'h00);
        // sprite 0 at line 0, then a tick: flags clear and the hit lands together
        add_row(vcri_pkg::CMD_DMA,   vcri_pkg::REG_CTRL,    8'h00, 8'h00, 8'h00);
        add_row(vcri_pkg::CMD_TICK,  vcri_pkg::REG_CTRL,    8'h00, 8'h00, 8'h00);

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
        drain_responses();

        while (words_sent < RANDOM_TARGET) begin
            if (!paused && words_sent >= 650) begin
                drain_responses();
                paused = 1'b1;
            end
            send_random_sequence();
        end

        in_if.valid <= 1'b0;
        waited = 0;
        while (responses_due.size() != 0 && waited < 4000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);   // room for any stray result
        if (responses_due.size() != 0)
            report_mismatch($sformatf("%0d results never came out", responses_due.size()));

        $display("Covered %0d words: %0d scanline ticks, %0d frame wraps, %0d NMIs,",
                 words_sent, n_ticks, n_frames, n_nmi);
        $display("%0d video-memory accesses, one %0d-cycle result hold-off; %0d mismatches.",
                 n_vram, HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
